// File: hdl/dpwr_pkg.sv
// Shared types, constants and multiply job table for the dual prediction
// window regression block. No dependencies.
package dpwr_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 32;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned TIME_W     = 28;
  localparam int unsigned COEF_W     = 48;
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Q16.16 scale of the intercept and 2^-32 scale of the prediction
  localparam int unsigned ICPT_SHIFT = 16;
  localparam int unsigned PRED_SHIFT = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd16384;
  localparam logic [THR_W-1:0]   THR_RST   = 16'd2;
  localparam logic [LEN_W-1:0]   LEN_RST   = 6'd20;
  localparam logic [LEN_W-1:0]   LEN_MIN   = 6'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA      = 2'd0,
    REG_THRESHOLD  = 2'd1,
    REG_WINDOW_LEN = 2'd2
  } cfg_reg_e;

  // multiplicand / multiplier / accumulator start / result destination
  typedef enum logic [2:0] {
    OPA_SXX, OPA_SX, OPA_SXY, OPA_SENT_SLOPE, OPA_DIFF_SLOPE
  } opa_e;

  typedef enum logic [1:0] {
    OPB_N, OPB_SX, OPB_SY, OPB_TIME
  } opb_e;

  typedef enum logic [1:0] {
    INIT_ZERO, INIT_KEEP, INIT_SENT_ICPT, INIT_DIFF_ICPT
  } init_e;

  typedef enum logic [2:0] {
    CAP_NONE, CAP_DEN, CAP_NK, CAP_NM, CAP_PS, CAP_DIFF
  } cap_e;

  typedef logic [2:0] job_idx_t;

  localparam job_idx_t JOB_DEN_A     = 3'd0;
  localparam job_idx_t JOB_DEN_B     = 3'd1;
  localparam job_idx_t JOB_NK_A      = 3'd2;
  localparam job_idx_t JOB_NK_B      = 3'd3;
  localparam job_idx_t JOB_NM_A      = 3'd4;
  localparam job_idx_t JOB_NM_B      = 3'd5;
  localparam job_idx_t JOB_PRED_SENT = 3'd6;
  localparam job_idx_t JOB_PRED_DIFF = 3'd7;

  typedef struct packed {
    opa_e  opa;
    opb_e  opb;
    init_e init;
    logic  neg;
    cap_e  cap;
  } mul_job_t;

  // D = n*Sxx - Sx*Sx, nk = n*Sxy - Sx*Sy, nm = Sy*Sxx - Sx*Sxy,
  // Psent = sent_slope*t + sent_icpt<<16, diff = dslope*t + dicpt<<16
  function automatic mul_job_t mul_job(input job_idx_t idx);
    mul_job_t j;
    j = '{opa: OPA_SXX, opb: OPB_N, init: INIT_ZERO, neg: 1'b0, cap: CAP_NONE};
    unique case (idx)
      JOB_DEN_A:     j = '{OPA_SXX, OPB_N, INIT_ZERO, 1'b0, CAP_NONE};
      JOB_DEN_B:     j = '{OPA_SX, OPB_SX, INIT_KEEP, 1'b1, CAP_DEN};
      JOB_NK_A:      j = '{OPA_SXY, OPB_N, INIT_ZERO, 1'b0, CAP_NONE};
      JOB_NK_B:      j = '{OPA_SX, OPB_SY, INIT_KEEP, 1'b1, CAP_NK};
      JOB_NM_A:      j = '{OPA_SXX, OPB_SY, INIT_ZERO, 1'b0, CAP_NONE};
      JOB_NM_B:      j = '{OPA_SXY, OPB_SX, INIT_KEEP, 1'b1, CAP_NM};
      JOB_PRED_SENT: j = '{OPA_SENT_SLOPE, OPB_TIME, INIT_SENT_ICPT, 1'b0, CAP_PS};
      JOB_PRED_DIFF: j = '{OPA_DIFF_SLOPE, OPB_TIME, INIT_DIFF_ICPT, 1'b0, CAP_DIFF};
      default:       j = '{OPA_SXX, OPB_N, INIT_ZERO, 1'b0, CAP_NONE};
    endcase
    return j;
  endfunction

  typedef struct packed {
    logic     load_in;
    logic     smooth_mul;
    logic     smooth_sum;
    logic     store;
    logic     sum_clr;
    logic     sum_rd;
    logic     sum_mul;
    logic     sum_acc;
    logic     mul_start;
    job_idx_t job_idx;
    logic     div_start;
    logic     div_icpt;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic warm;
    logic sum_last;
    logic mul_done;
    logic div_done;
    logic den_zero;
    logic emit;
    logic out_busy;
  } sts_t;

endpackage

// File: hdl/dual_prediction_window_regression.sv
// Top level of the dual prediction window regression block.
// Depends on dpwr_pkg, dpwr_ctrl and dpwr_datapath.
//
// Each input transaction carries a Q16.16 sample and its time in ms. The
// sample is smoothed by an exponential average (alpha in Q1.16) and written
// to a ring window of window_len entries along with its time. The first
// window_len transactions only fill the window (time stored as zero) and
// produce nothing. Afterwards each transaction replaces the oldest entry, a
// least-squares line is fitted over the window and evaluated at the
// transaction's time, and compared with the line last sent; when the two
// predictions differ by more than the threshold in value units, or the sent
// prediction is zero, one output transaction carries the new slope (Q16.32
// per ms), intercept (Q32.16) and time, and that line becomes the sent line.
// A zero fit denominator keeps the previous fit. One transaction is worked
// on at a time: a warm-up item passes through accept, smoothing multiply,
// smoothing sum and store before the next acceptance. A fitting item adds
// the window walk (read, multiply, accumulate per entry), the bit-serial
// multiply-accumulate jobs (MB = 33 + log2 WindowMax, 38 at the default),
// the restoring divider (W = 96 + 2*log2 WindowMax, 106 at the default)
// and a decision state; both divisions are skipped when the denominator
// is zero. The result sits in an output register, so a new input is taken
// while the previous result waits; only a second result that finds the
// register still full holds the decision state until it is taken.
// Configuration is written through a plain write port: index 0 alpha, 1
// threshold, 2 window_len; writes are meant for idle periods only. No
// clearing pass is needed after reset.
module dual_prediction_window_regression import dpwr_pkg::*; #(
  parameter int unsigned WindowMax = WINDOW_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [TIME_W-1:0]   time_ms_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [TIME_W-1:0]   sent_time_ms_o,
  output logic signed [COEF_W-1:0]   slope_o,
  output logic signed [COEF_W-1:0]   intercept_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: accepts a transaction only when idle
  dpwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // window, sums, shared multiplier and divider, result register
  dpwr_datapath #(
    .WindowMax (WindowMax)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_i       (sample_i),
    .time_ms_i      (time_ms_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .sent_time_ms_o (sent_time_ms_o),
    .slope_o        (slope_o),
    .intercept_o    (intercept_o)
  );

endmodule

// File: hdl/dpwr_ctrl.sv
// Sequencer for the dual prediction window regression block.
// Depends on dpwr_pkg; drives commands to dpwr_datapath.
module dpwr_ctrl import dpwr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SMOOTH_MUL, ST_SMOOTH_SUM, ST_STORE, ST_SUM_RD, ST_SUM_MUL,
    ST_SUM_ACC, ST_JOB_GO, ST_JOB_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_DECIDE
  } state_e;

  state_e   state_q, state_d;
  job_idx_t job_q, job_d;
  logic     div_icpt_q, div_icpt_d;

  always_comb begin
    state_d        = state_q;
    job_d          = job_q;
    div_icpt_d     = div_icpt_q;
    cmd_o          = '0;
    cmd_o.job_idx  = job_q;
    cmd_o.div_icpt = div_icpt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_SMOOTH_MUL;
        end
      end
      ST_SMOOTH_MUL: begin
        cmd_o.smooth_mul = 1'b1;
        state_d          = ST_SMOOTH_SUM;
      end
      ST_SMOOTH_SUM: begin
        cmd_o.smooth_sum = 1'b1;
        state_d          = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.store   = 1'b1;
        cmd_o.sum_clr = 1'b1;
        state_d       = sts_i.warm ? ST_IDLE : ST_SUM_RD;
      end
      ST_SUM_RD: begin
        cmd_o.sum_rd = 1'b1;
        state_d      = ST_SUM_MUL;
      end
      ST_SUM_MUL: begin
        cmd_o.sum_mul = 1'b1;
        state_d       = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cmd_o.sum_acc = 1'b1;
        if (sts_i.sum_last) begin
          job_d   = JOB_DEN_A;
          state_d = ST_JOB_GO;
        end else begin
          state_d = ST_SUM_RD;
        end
      end
      ST_JOB_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_JOB_WAIT;
      end
      ST_JOB_WAIT: begin
        if (sts_i.mul_done) begin
          if (job_q == JOB_NM_B) begin
            if (sts_i.den_zero) begin
              // singular fit: keep the old line, go straight to prediction
              job_d   = JOB_PRED_SENT;
              state_d = ST_JOB_GO;
            end else begin
              div_icpt_d = 1'b0;
              state_d    = ST_DIV_GO;
            end
          end else if (job_q == JOB_PRED_DIFF) begin
            state_d = ST_DECIDE;
          end else begin
            job_d   = 3'(job_q + 3'd1);
            state_d = ST_JOB_GO;
          end
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          if (!div_icpt_q) begin
            div_icpt_d = 1'b1;
            state_d    = ST_DIV_GO;
          end else begin
            job_d   = JOB_PRED_SENT;
            state_d = ST_JOB_GO;
          end
        end
      end
      ST_DECIDE: begin
        if (!sts_i.emit) begin
          state_d = ST_IDLE;
        end else if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      job_q      <= JOB_DEN_A;
      div_icpt_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      job_q      <= job_d;
      div_icpt_q <= div_icpt_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: hdl/dpwr_datapath.sv
// Datapath: config registers, smoother, window memory, running sums,
// serial multiply-accumulate, restoring divider, output register.
// Depends on dpwr_pkg; commanded by dpwr_ctrl.
module dpwr_datapath import dpwr_pkg::*; #(
  parameter int unsigned WindowMax = WINDOW_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [TIME_W-1:0]   time_ms_i,
  input  logic                       out_stall_i,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  output logic                       out_valid_o,
  output logic signed [TIME_W-1:0]   sent_time_ms_o,
  output logic signed [COEF_W-1:0]   slope_o,
  output logic signed [COEF_W-1:0]   intercept_o
);

  localparam int unsigned LG    = $clog2(WindowMax);
  localparam int unsigned IW    = (LG < 1) ? 1 : LG;
  localparam int unsigned NW    = $clog2(WindowMax + 1);
  localparam int unsigned SX_W  = TIME_W + LG;
  localparam int unsigned SXX_W = 2 * TIME_W + LG;
  localparam int unsigned SY_W  = SAMPLE_W + LG;
  localparam int unsigned SXY_W = TIME_W + SAMPLE_W + LG;
  localparam int unsigned MB    = SAMPLE_W + LG + 1;
  localparam int unsigned W     = 3 * SAMPLE_W + 2 * LG;
  localparam int unsigned MCW   = $clog2(MB);
  localparam int unsigned DCW   = $clog2(W);
  localparam int unsigned WORD_W = SAMPLE_W + TIME_W;

  // ---------------- configuration ----------------
  logic [ALPHA_W-1:0] alpha_q;
  logic [THR_W-1:0]   thr_q;
  logic [LEN_W-1:0]   len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      thr_q   <= THR_RST;
      len_q   <= LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ALPHA:      alpha_q <= cfg_wdata_i[ALPHA_W-1:0];
        REG_THRESHOLD:  thr_q   <= cfg_wdata_i[THR_W-1:0];
        REG_WINDOW_LEN: len_q   <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_eff;
  always_comb begin
    if (len_q < LEN_MIN)                 n_eff = NW'(LEN_MIN);
    else if (32'(len_q) > 32'(WindowMax)) n_eff = NW'(WindowMax);
    else                                 n_eff = NW'(len_q);
  end

  // ---------------- input and smoothing ----------------
  logic signed [SAMPLE_W-1:0] smp_q, sv_q;
  logic signed [TIME_W-1:0]   tim_q;
  logic signed [49:0]         sm_p1_q, sm_p2_q;
  logic [ALPHA_W-1:0]         a_eff;
  logic [ALPHA_W:0]           a_rest;
  logic signed [50:0]         sm_sum;

  assign a_eff  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign a_rest = (ALPHA_W+1)'(ALPHA_ONE) - {1'b0, a_eff};
  assign sm_sum = 51'(sm_p1_q) + 51'(sm_p2_q) + 51'(32768);

  // ---------------- window ----------------
  logic [WORD_W-1:0]  mem [WindowMax];
  logic [WindowMax-1:0] vld_q;
  logic [WORD_W-1:0]  rd_word_q;
  logic               rd_vld_q;
  logic [IW-1:0]      slot_q, slot_eff, slot_next, idx_q;
  logic [NW-1:0]      warm_cnt_q, slot_inc;
  logic               warm;

  assign warm      = (warm_cnt_q < n_eff);
  assign slot_eff  = (NW'(slot_q) >= n_eff) ? '0 : slot_q;
  assign slot_inc  = NW'(slot_eff) + NW'(1);
  assign slot_next = (slot_inc >= n_eff) ? '0 : IW'(slot_inc);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem[slot_eff] <= {sv_q, warm ? TIME_W'(0) : tim_q};
    if (cmd_i.sum_rd) begin
      rd_word_q <= mem[idx_q];
      rd_vld_q  <= vld_q[idx_q];
    end
  end

  logic signed [TIME_W-1:0]          xv;
  logic signed [SAMPLE_W-1:0]        yv;
  logic signed [2*TIME_W-1:0]        xx_q;
  logic signed [TIME_W+SAMPLE_W-1:0] xy_q;
  logic signed [SX_W-1:0]            sx_q;
  logic signed [SXX_W-1:0]           sxx_q;
  logic signed [SY_W-1:0]            sy_q;
  logic signed [SXY_W-1:0]           sxy_q;

  // entries never written read as zero
  assign xv = rd_vld_q ? $signed(rd_word_q[TIME_W-1:0]) : '0;
  assign yv = rd_vld_q ? $signed(rd_word_q[WORD_W-1:TIME_W]) : '0;

  // ---------------- fit registers ----------------
  logic signed [COEF_W-1:0] fit_slope_q, fit_icpt_q, sent_slope_q, sent_icpt_q;
  logic signed [W-1:0]      den_q, nk_q, nm_q, diff_q;
  logic                     ps_zero_q;

  // ---------------- serial multiply-accumulate ----------------
  mul_job_t            job;
  logic signed [W-1:0] opa, init_val, mul_a_q, acc_q, term, acc_step;
  logic signed [MB-1:0] opb, mul_b_q;
  logic signed [COEF_W:0] d_slope, d_icpt;
  logic signed [W-1:0] sent_icpt_ext, d_icpt_ext;
  logic                mul_busy_q, mul_neg_q, mul_last, mul_sub;
  logic [MCW-1:0]      mul_cnt_q;
  cap_e                mul_cap_q;

  assign job           = mul_job(cmd_i.job_idx);
  assign d_slope       = (COEF_W+1)'(fit_slope_q) - (COEF_W+1)'(sent_slope_q);
  assign d_icpt        = (COEF_W+1)'(fit_icpt_q) - (COEF_W+1)'(sent_icpt_q);
  assign sent_icpt_ext = W'(sent_icpt_q);
  assign d_icpt_ext    = W'(d_icpt);

  always_comb begin
    case (job.opa)
      OPA_SXX:        opa = W'(sxx_q);
      OPA_SX:         opa = W'(sx_q);
      OPA_SXY:        opa = W'(sxy_q);
      OPA_SENT_SLOPE: opa = W'(sent_slope_q);
      OPA_DIFF_SLOPE: opa = W'(d_slope);
      default:        opa = '0;
    endcase
    case (job.opb)
      OPB_N:    opb = $signed(MB'(n_eff));
      OPB_SX:   opb = MB'(sx_q);
      OPB_SY:   opb = MB'(sy_q);
      OPB_TIME: opb = MB'(tim_q);
      default:  opb = '0;
    endcase
    case (job.init)
      INIT_ZERO:      init_val = '0;
      INIT_KEEP:      init_val = acc_q;
      INIT_SENT_ICPT: init_val = sent_icpt_ext <<< ICPT_SHIFT;
      INIT_DIFF_ICPT: init_val = d_icpt_ext <<< ICPT_SHIFT;
      default:        init_val = '0;
    endcase
  end

  // the multiplier's top bit carries negative weight
  assign mul_last = (mul_cnt_q == MCW'(MB - 1));
  assign term     = mul_b_q[0] ? mul_a_q : '0;
  assign mul_sub  = mul_neg_q ^ mul_last;
  assign acc_step = mul_sub ? (acc_q - term) : (acc_q + term);

  // ---------------- restoring divider ----------------
  logic signed [W-1:0] div_num, div_num_abs, den_abs;
  logic [W-1:0]        dv_n_q, dv_d_q, dv_r_q, dv_qt_q, dv_r2, dv_r_nx, dv_q_nx;
  logic [W-1:0]        lim_pos, lim, mag;
  logic signed [W-1:0] quot;
  logic                dv_busy_q, dv_neg_q, dv_icpt_q, dv_last, dv_ge;
  logic [DCW-1:0]      dv_cnt_q;

  assign div_num     = cmd_i.div_icpt ? nm_q : (nk_q <<< ICPT_SHIFT);
  assign div_num_abs = div_num[W-1] ? -div_num : div_num;
  assign den_abs     = den_q[W-1] ? -den_q : den_q;
  assign dv_r2       = {dv_r_q[W-2:0], dv_n_q[W-1]};
  assign dv_ge       = (dv_r2 >= dv_d_q);
  assign dv_r_nx     = dv_ge ? (dv_r2 - dv_d_q) : dv_r2;
  assign dv_q_nx     = {dv_qt_q[W-2:0], dv_ge};
  assign dv_last     = (dv_cnt_q == DCW'(W - 1));
  assign lim_pos     = W'({1'b0, {(COEF_W-1){1'b1}}});
  assign lim         = dv_neg_q ? (lim_pos + W'(1)) : lim_pos;
  assign mag         = (dv_q_nx > lim) ? lim : dv_q_nx;
  assign quot        = dv_neg_q ? -$signed(mag) : $signed(mag);

  // ---------------- comparison ----------------
  logic [W-1:0] diff_abs, thr_ext;
  assign diff_abs = diff_q[W-1] ? W'(-diff_q) : W'(diff_q);
  assign thr_ext  = W'(thr_q) << PRED_SHIFT;

  // ---------------- registers without reset ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      smp_q <= sample_i;
      tim_q <= time_ms_i;
    end
    if (cmd_i.smooth_mul) begin
      sm_p1_q <= $signed({1'b0, a_eff}) * smp_q;
      sm_p2_q <= $signed(a_rest) * sv_q;
    end
    if (cmd_i.sum_mul) begin
      xx_q <= xv * xv;
      xy_q <= xv * yv;
    end
    if (cmd_i.sum_clr) begin
      sx_q  <= '0;
      sxx_q <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
    end else if (cmd_i.sum_acc) begin
      sx_q  <= sx_q + SX_W'(xv);
      sxx_q <= sxx_q + SXX_W'(xx_q);
      sy_q  <= sy_q + SY_W'(yv);
      sxy_q <= sxy_q + SXY_W'(xy_q);
    end
    if (cmd_i.mul_start) begin
      mul_a_q   <= opa;
      mul_b_q   <= opb;
      acc_q     <= init_val;
      mul_neg_q <= job.neg;
      mul_cap_q <= job.cap;
    end else if (mul_busy_q) begin
      mul_a_q <= mul_a_q <<< 1;
      mul_b_q <= mul_b_q >>> 1;
      acc_q   <= acc_step;
      if (mul_last) begin
        case (mul_cap_q)
          CAP_DEN:  den_q     <= acc_step;
          CAP_NK:   nk_q      <= acc_step;
          CAP_NM:   nm_q      <= acc_step;
          CAP_PS:   ps_zero_q <= (acc_step == '0);
          CAP_DIFF: diff_q    <= acc_step;
          default: ;
        endcase
      end
    end
    if (cmd_i.div_start) begin
      dv_n_q    <= div_num_abs;
      dv_d_q    <= den_abs;
      dv_r_q    <= '0;
      dv_qt_q   <= '0;
      dv_neg_q  <= div_num[W-1] ^ den_q[W-1];
      dv_icpt_q <= cmd_i.div_icpt;
    end else if (dv_busy_q) begin
      dv_n_q  <= dv_n_q << 1;
      dv_r_q  <= dv_r_nx;
      dv_qt_q <= dv_q_nx;
    end
    if (cmd_i.out_load) begin
      sent_time_ms_o <= tim_q;
      slope_o        <= fit_slope_q;
      intercept_o    <= fit_icpt_q;
    end
  end

  // ---------------- control and model state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q         <= '0;
      vld_q        <= '0;
      slot_q       <= '0;
      warm_cnt_q   <= '0;
      idx_q        <= '0;
      fit_slope_q  <= '0;
      fit_icpt_q   <= '0;
      sent_slope_q <= '0;
      sent_icpt_q  <= '0;
      mul_busy_q   <= 1'b0;
      mul_cnt_q    <= '0;
      dv_busy_q    <= 1'b0;
      dv_cnt_q     <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      if (cmd_i.smooth_sum) sv_q <= sm_sum[SAMPLE_W+15:16];
      if (cmd_i.store) begin
        vld_q[slot_eff] <= 1'b1;
        slot_q          <= slot_next;
        if (warm) warm_cnt_q <= NW'(warm_cnt_q + NW'(1));
      end
      if (cmd_i.sum_clr)      idx_q <= '0;
      else if (cmd_i.sum_acc) idx_q <= IW'(idx_q + IW'(1));

      if (cmd_i.mul_start) begin
        mul_busy_q <= 1'b1;
        mul_cnt_q  <= '0;
      end else if (mul_busy_q) begin
        mul_cnt_q <= MCW'(mul_cnt_q + MCW'(1));
        if (mul_last) mul_busy_q <= 1'b0;
      end

      if (cmd_i.div_start) begin
        dv_busy_q <= 1'b1;
        dv_cnt_q  <= '0;
      end else if (dv_busy_q) begin
        dv_cnt_q <= DCW'(dv_cnt_q + DCW'(1));
        if (dv_last) begin
          dv_busy_q <= 1'b0;
          if (dv_icpt_q) fit_icpt_q  <= quot[COEF_W-1:0];
          else           fit_slope_q <= quot[COEF_W-1:0];
        end
      end

      if (cmd_i.out_load) begin
        out_valid_o  <= 1'b1;
        sent_slope_q <= fit_slope_q;
        sent_icpt_q  <= fit_icpt_q;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // ---------------- status ----------------
  always_comb begin
    sts_o.warm     = warm;
    sts_o.sum_last = (NW'(idx_q) == NW'(n_eff - NW'(1)));
    sts_o.mul_done = mul_busy_q & mul_last;
    sts_o.div_done = dv_busy_q & dv_last;
    sts_o.den_zero = (den_q == '0);
    sts_o.emit     = (diff_abs > thr_ext) || ps_zero_q;
    sts_o.out_busy = out_valid_o;
  end

  // ---------------- assertions ----------------
  a_mul_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_start |-> !mul_busy_q && !dv_busy_q)
    else $error("multiply started while a unit is busy");

  a_div_nonzero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (den_q != '0) && !mul_busy_q)
    else $error("divide started on zero denominator or busy multiplier");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_busy_q && dv_busy_q))
    else $error("multiplier and divider both busy");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_o)
    else $error("result register overwritten before it was taken");

endmodule

// File: bench/dual_prediction_window_regression_tb.sv
// Self-checking testbench for dual_prediction_window_regression.
// Depends on dpwr_pkg and the RTL of the block; no files or arguments.
`timescale 1ns / 1ps

module dual_prediction_window_regression_tb;
  import dpwr_pkg::*;

  localparam int unsigned WIN_MAX    = 32;
  localparam int          SETTLE     = 1200;   // idle cycles
  localparam int          WD_LIMIT   = 30000;  // cycles with no transaction at all
  localparam int          RAND_ITEMS = 950;

  typedef logic signed [127:0] wide_t;

  // expected output transaction
  typedef struct {
    logic signed [TIME_W-1:0] t;
    logic signed [COEF_W-1:0] slope;
    logic signed [COEF_W-1:0] icpt;
  } line_t;

  // directed row: how the result is known
  typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_ZERO_LINE} row_kind_e;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [TIME_W-1:0]   t;
    row_kind_e                  kind;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic signed [TIME_W-1:0] time_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [TIME_W-1:0] sent_time;
  logic signed [COEF_W-1:0] slope;
  logic signed [COEF_W-1:0] intercept;

  always #6 clk_i = ~clk_i;

  dual_prediction_window_regression i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .time_ms_i      (time_ms),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sent_time_ms_o (sent_time),
    .slope_o        (slope),
    .intercept_o    (intercept)
  );

  // ---------------------------------------------------------------------
  // Line-fit predictor: own copy of registers and window state
  // ---------------------------------------------------------------------
  logic [ALPHA_W-1:0] p_alpha = ALPHA_RST;
  logic [THR_W-1:0]   p_thr   = THR_RST;
  logic [LEN_W-1:0]   p_len   = LEN_RST;
  int                 ewma_val;
  int                 win_val [WIN_MAX];
  int                 win_time[WIN_MAX];
  int unsigned        slot, warm_cnt;
  longint             fit_k, fit_b, sent_k, sent_b;

  line_t pending_lines[$];
  int    mismatches = 0;
  int    accepted_cycle_gap = 0;

  initial begin
    ewma_val = 0;
    foreach (win_val[i]) begin
      win_val[i]  = 0;
      win_time[i] = 0;
    end
    slot = 0; warm_cnt = 0;
    fit_k = 0; fit_b = 0; sent_k = 0; sent_b = 0;
  end

  // quotient truncated toward zero, clamped to 48-bit signed
  function automatic longint sat_div(input wide_t num, input wide_t den);
    wide_t q;
    q = num / den;
    if (q > 128'sd140737488355327) return 64'sd140737488355327;
    if (q < -128'sd140737488355328) return -64'sd140737488355328;
    return longint'(q);
  endfunction

  function automatic wide_t line_at(input longint k, input longint b, input longint t);
    return wide_t'(k) * wide_t'(t) + wide_t'(b) * 128'sd65536;
  endfunction

  // one input transaction; returns 1 and the line when one is sent
  function automatic bit predict_line(input logic signed [SAMPLE_W-1:0] s_in,
                                      input logic signed [TIME_W-1:0] t_in,
                                      output line_t res);
    longint a, acc, t;
    int unsigned n;
    bit warm;
    wide_t sx, sxx, sy, sxy, x, y, den, wn, pf, ps, diff, thr;
    t = longint'(t_in);
    a = (p_alpha > ALPHA_ONE) ? 65536 : longint'(p_alpha);
    acc = a * longint'(s_in) + (65536 - a) * longint'(ewma_val) + 32768;
    ewma_val = int'(acc >>> 16);   // floor division by 2^16
    n = p_len;
    if (n < 2) n = 2;
    if (n > WIN_MAX) n = WIN_MAX;
    if (slot >= n) slot = 0;
    warm = warm_cnt < n;
    win_val[slot]  = ewma_val;
    win_time[slot] = warm ? 0 : int'(t);
    slot++;
    if (slot >= n) slot = 0;
    if (warm) begin
      warm_cnt++;
      return 1'b0;
    end
    sx = 0; sxx = 0; sy = 0; sxy = 0;
    for (int i = 0; i < n; i++) begin
      x = wide_t'(win_time[i]);
      y = wide_t'(win_val[i]);
      sx += x; sxx += x * x; sy += y; sxy += x * y;
    end
    wn = wide_t'(n);
    den = wn * sxx - sx * sx;
    if (den != 0) begin
      fit_k = sat_div((wn * sxy - sx * sy) * 128'sd65536, den);
      fit_b = sat_div(sy * sxx - sx * sxy, den);
    end
    pf = line_at(fit_k, fit_b, t);
    ps = line_at(sent_k, sent_b, t);
    diff = pf - ps;
    if (diff < 0) diff = -diff;
    thr = wide_t'({1'b0, p_thr}) <<< 32;
    if (diff > thr || ps == 0) begin
      sent_k = fit_k;
      sent_b = fit_b;
      res.t = t_in;
      res.slope = fit_k[COEF_W-1:0];
      res.icpt = fit_b[COEF_W-1:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string what, input longint exp_v, input longint got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0d (0x%0h) got %0d (0x%0h)",
               what, exp_v, exp_v, got_v, got_v);
  endtask

  // ---------------------------------------------------------------------
  // Receive side: stall pattern changes mode every so often
  // ---------------------------------------------------------------------
  int stall_mode = 0;
  int stall_tick = 0;

  always @(posedge clk_i) begin
    if (stall_tick == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_tick <= $urandom_range(50, 400);
    end else begin
      stall_tick <= stall_tick - 1;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;                        // stretches with no stall
      end
      1: begin
        out_stall <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        out_stall <= (stall_tick % 40) < 30;      // long stall, short window
      end
      default: begin
        out_stall <= (stall_tick % 3) == 0;
      end
    endcase
  end

  // output checker; values read here are those before the edge
  always @(posedge clk_i) begin
    line_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_lines.size() == 0) begin
        note_mismatch("unexpected output transaction, time", 0, longint'(sent_time));
      end else begin
        want = pending_lines.pop_front();
        if (sent_time !== want.t) note_mismatch("sent_time_ms", want.t, sent_time);
        if (slope !== want.slope) note_mismatch("slope", want.slope, slope);
        if (intercept !== want.icpt) note_mismatch("intercept", want.icpt, intercept);
      end
    end
  end

  // watchdog: any cycle without a transaction on either channel counts
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      accepted_cycle_gap <= 0;
    else
      accepted_cycle_gap <= accepted_cycle_gap + 1;
    if (accepted_cycle_gap >= WD_LIMIT) begin
      $display("watchdog expired with %0d lines outstanding", pending_lines.size());
      $display("dual_prediction_window_regression verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Send side
  // ---------------------------------------------------------------------
  int burst_left = 0;

  // waits for all expected lines, then lets the block finish a quiet item
  task automatic wait_idle();
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write enable stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      REG_ALPHA:      p_alpha = val[ALPHA_W-1:0];
      REG_THRESHOLD:  p_thr   = val[THR_W-1:0];
      REG_WINDOW_LEN: p_len   = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // the last item was accepted at this edge; drop valid before going idle
  task automatic set_config(input logic [CFG_DATA_W-1:0] a,
                            input logic [CFG_DATA_W-1:0] thr,
                            input logic [CFG_DATA_W-1:0] len);
    in_valid <= 1'b0;
    wait_idle();
    write_reg(REG_ALPHA, a);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WINDOW_LEN, len);
    cfg_we <= 1'b0;
  endtask

  // one input transaction; returns with the handshake done at this edge
  task automatic send_item(input logic signed [SAMPLE_W-1:0] s,
                           input logic signed [TIME_W-1:0] t,
                           output bit emitted, output line_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample   <= s;
    time_ms  <= t;
    do @(posedge clk_i); while (in_stall);
    emitted = predict_line(s, t, res);
    if (emitted) pending_lines.push_back(res);
  endtask

  row_t directed[$];

  initial begin
    bit emitted;
    line_t res;
    int sent_items;
    int phase_items;
    longint tbase;
    int walk;
    logic [CFG_DATA_W-1:0] a_cfg, t_cfg, l_cfg;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: alpha above one, zero threshold, window below minimum.
    // Two warm-up items, then an item at time zero: the window times are all
    // zero, so the denominator is singular, the fit stays zero, and the sent
    // prediction of zero forces a zero line out.
    set_config(17'h1FFFF, 17'd0, 17'd0);
    directed.push_back('{32'sh7FFFFFFF, 28'sd0, ROW_QUIET});
    directed.push_back('{32'sh80000000, 28'sd5, ROW_QUIET});
    directed.push_back('{32'sh00010000, 28'sd0, ROW_ZERO_LINE});
    directed.push_back('{32'sh7FFFFFFF, 28'sd86400000, ROW_MODEL});
    directed.push_back('{32'sh80000000, -28'sd3600000, ROW_MODEL});
    directed.push_back('{32'sh00000000, 28'sh7FFFFFF, ROW_MODEL});
    directed.push_back('{32'shFFFFFFFF, 28'sh8000000, ROW_MODEL});
    directed.push_back('{32'sh7FFFFFFF, 28'sh7FFFFFF, ROW_MODEL});
    directed.push_back('{32'sh80000000, 28'sh8000000, ROW_MODEL});
    directed.push_back('{32'sh12345678, 28'sd1000, ROW_MODEL});
    directed.push_back('{32'sh12345678, 28'sd1000, ROW_MODEL}); // equal times
    directed.push_back('{32'sh00020000, 28'sd2000, ROW_MODEL});
    foreach (directed[i]) begin
      send_item(directed[i].sample, directed[i].t, emitted, res);
      case (directed[i].kind)
        ROW_QUIET: if (emitted) note_mismatch("warm-up item sent a line", 0, 1);
        ROW_ZERO_LINE: begin
          if (!emitted || res.slope != 0 || res.icpt != 0 || res.t != directed[i].t)
            note_mismatch("zero line at singular window", 1, emitted);
        end
        default: ;
      endcase
    end

    // window grown mid-run: old entries kept, warm-up resumes to the new length
    set_config(17'd65536, 17'd65535, 17'd3);
    for (int i = 0; i < 6; i++)
      send_item($urandom, TIME_W'(100 * i), emitted, res);
    // window shrunk back to the minimum length
    set_config(17'd0, 17'd1, 17'd2);
    for (int i = 0; i < 4; i++)
      send_item($urandom, TIME_W'(50 * i + 7), emitted, res);

    // Random part: phases of well-formed rising time series with random
    // content, sprinkled with arbitrary bit patterns.
    sent_items = 0;
    tbase = -3600000;
    walk = 0;
    while (sent_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: a_cfg = 17'd0;
        1: a_cfg = 17'd65536;
        2: a_cfg = CFG_DATA_W'($urandom_range(65537, 131071));
        default: a_cfg = CFG_DATA_W'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 7))
        0: t_cfg = 17'd0;
        1: t_cfg = 17'd65535;
        2: t_cfg = CFG_DATA_W'($urandom_range(0, 65535));
        default: t_cfg = CFG_DATA_W'($urandom_range(0, 40));
      endcase
      case ($urandom_range(0, 11))
        0: l_cfg = 17'd32;
        1: l_cfg = CFG_DATA_W'($urandom_range(33, 63));
        2: l_cfg = CFG_DATA_W'($urandom_range(0, 1));
        3: l_cfg = {11'd0, 6'($urandom)};
        default: l_cfg = CFG_DATA_W'($urandom_range(2, 10));
      endcase
      set_config(a_cfg, t_cfg, l_cfg);
      phase_items = $urandom_range(40, 90);
      for (int i = 0; i < phase_items; i++) begin
        logic signed [SAMPLE_W-1:0] s;
        logic signed [TIME_W-1:0] t;
        if ($urandom_range(0, 9) == 0) begin
          s = $urandom;
          t = TIME_W'($urandom);
        end else begin
          walk += $signed($urandom_range(0, 200000)) - 100000;
          s = walk;
          tbase += $urandom_range(1, 3000);
          if (tbase > 86400000) tbase = -3600000;
          t = TIME_W'(tbase);
        end
        send_item(s, t, emitted, res);
        sent_items++;
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    if (mismatches == 0)
      $display("dual_prediction_window_regression verification clean");
    else
      $display("dual_prediction_window_regression verification failed");
    $finish;
  end

endmodule
